// ----- rtl/swm_pkg.sv -----
`default_nettype none

package swm_pkg;

   // Fixed datapath widths
   localparam int ACC_BITS    = 48;
   localparam int FREQ_BITS   = 32;
   localparam int WLEN_BITS   = 16;
   localparam int RMS_BITS    = 16;
   localparam int ROOT_BITS   = ACC_BITS / 2;
   localparam int SREM_BITS   = ROOT_BITS + 2;
   localparam int STEP_BITS   = $clog2(ACC_BITS);

   // Job queue between front and back
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
   localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

   // Register port
   localparam int CSR_AW = 2;
   localparam int CSR_DW = 32;

   typedef enum logic [CSR_AW-1:0] {
      CSR_WINDOW_LENGTH   = 2'd0,
      CSR_START_FREQUENCY = 2'd1,
      CSR_STOP_FREQUENCY  = 2'd2,
      CSR_FREQUENCY_STEP  = 2'd3
   } csr_index_type;

   // One finished measure window waiting for divide and root
   typedef struct packed {
      logic [FREQ_BITS-1:0] freq;
      logic [ACC_BITS-1:0]  power_sum;
   } job_type;

   // Static configuration seen by front and back
   typedef struct packed {
      logic [WLEN_BITS-1:0] window_length;
      logic [FREQ_BITS-1:0] stop_frequency;
      logic [FREQ_BITS-1:0] frequency_step;
   } cfg_type;

   // Reload of the sweep frequency on a start_frequency write
   typedef struct packed {
      logic                 load;
      logic [FREQ_BITS-1:0] value;
   } freq_load_type;

endpackage

`default_nettype wire

// ----- rtl/swept_windowed_rms_meter.sv -----
// Swept windowed RMS meter.
// req_ channel: one signed I/Q sample per beat (req_sample_q = 0 for a real
// signal). Windows alternate settle / measure, each window_length samples,
// settle first. A measure window sums i*i + q*q; at its end the sum is divided
// by the window length and square-rooted.
// rsp_ channel: one beat per measure window whose sweep frequency is not past
// stop_frequency, carrying that frequency and the RMS value; the frequency
// then steps by frequency_step (saturating).
// csr_ port: write-only, index 0 window_length, 1 start_frequency (also
// reloads the sweep frequency), 2 stop_frequency, 3 frequency_step.
// Throughput: one sample per cycle while req_ready is high. Each reported
// window passes the back end through queue pop, 48 divide steps, 24 root
// steps and output load, so input runs at full rate when window_length is
// 37 or more; shorter windows fill the 4-entry job queue and req_ready drops
// until it drains. A window result passes the squaring and power registers,
// the job queue, divide, root and the output register to rsp_valid. A stalled
// receiver holds it there; the back end finishes one more job and then waits.
// Reset: settle phase, zero count and sum, sweep frequency 0, window 1024.
`default_nettype none

module swept_windowed_rms_meter #(
   parameter int SAMPLE_BITS = 16
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output logic                              req_ready,
   input  wire logic [SAMPLE_BITS-1:0]       req_sample_i,
   input  wire logic [SAMPLE_BITS-1:0]       req_sample_q,
   output logic                              rsp_valid,
   input  wire logic                         rsp_ready,
   output logic [swm_pkg::FREQ_BITS-1:0]     rsp_sweep_frequency,
   output logic [swm_pkg::RMS_BITS-1:0]      rsp_rms_value,
   input  wire logic                         csr_we,
   input  wire logic [swm_pkg::CSR_AW-1:0]   csr_index,
   input  wire logic [swm_pkg::CSR_DW-1:0]   csr_wdata
);
   import swm_pkg::*;

   logic [WLEN_BITS-1:0]  wlen_ff;
   logic [FREQ_BITS-1:0]  stop_ff;
   logic [FREQ_BITS-1:0]  fstep_ff;
   cfg_type               cfg;
   freq_load_type         freq_load;

   logic                  q_push;
   logic                  q_pop;
   job_type               push_job;
   job_type               pop_job;
   logic [QCNT_BITS-1:0]  q_count;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         wlen_ff  <= WLEN_BITS'(1024);
         stop_ff  <= '0;
         fstep_ff <= FREQ_BITS'(1);
      end else if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_WINDOW_LENGTH:  wlen_ff  <= csr_wdata[WLEN_BITS-1:0];
            CSR_STOP_FREQUENCY: stop_ff  <= csr_wdata[FREQ_BITS-1:0];
            CSR_FREQUENCY_STEP: fstep_ff <= csr_wdata[FREQ_BITS-1:0];
            default: begin
            end
         endcase
      end
   end

   assign cfg.window_length  = wlen_ff;
   assign cfg.stop_frequency = stop_ff;
   assign cfg.frequency_step = fstep_ff;

   // A start_frequency write reloads the sweep
   assign freq_load.load  = csr_we && (csr_index_type'(csr_index) == CSR_START_FREQUENCY);
   assign freq_load.value = csr_wdata[FREQ_BITS-1:0];

   swm_front #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_sample_i (req_sample_i),
      .req_sample_q (req_sample_q),
      .cfg          (cfg),
      .freq_load    (freq_load),
      .q_count      (q_count),
      .q_push       (q_push),
      .q_job        (push_job)
   );

   swm_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_job (push_job),
      .pop      (q_pop),
      .pop_job  (pop_job),
      .count    (q_count)
   );

   swm_back u_back (
      .clock               (clock),
      .reset               (reset),
      .cfg                 (cfg),
      .q_count             (q_count),
      .q_job               (pop_job),
      .q_pop               (q_pop),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_sweep_frequency (rsp_sweep_frequency),
      .rsp_rms_value       (rsp_rms_value)
   );

endmodule

`default_nettype wire

// ----- rtl/swm_front.sv -----
`default_nettype none

module swm_front #(
   parameter int SAMPLE_BITS = 16
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic [SAMPLE_BITS-1:0]        req_sample_i,
   input  wire logic [SAMPLE_BITS-1:0]        req_sample_q,
   input  wire swm_pkg::cfg_type              cfg,
   input  wire swm_pkg::freq_load_type        freq_load,
   input  wire logic [swm_pkg::QCNT_BITS-1:0] q_count,
   output logic                               q_push,
   output swm_pkg::job_type                   q_job
);
   import swm_pkg::*;

   localparam int SQ_BITS  = 2 * SAMPLE_BITS - 1;
   localparam int PWR_BITS = SQ_BITS + 1;

   logic                  accept;
   logic                  window_end;
   logic [WLEN_BITS-1:0]  count_inc;

   logic                  settling_ff, settling_in;
   logic [WLEN_BITS-1:0]  count_ff, count_in;
   logic                  s1_valid_ff, s1_valid_in;
   logic                  s1_end_ff, s1_end_in;
   logic                  s2_valid_ff, s2_valid_in;
   logic                  s2_end_ff, s2_end_in;
   logic [ACC_BITS-1:0]   acc_ff, acc_in;
   logic [FREQ_BITS-1:0]  freq_ff, freq_in;

   logic signed [SAMPLE_BITS-1:0]   si, sq;
   logic signed [2*SAMPLE_BITS-1:0] prod_i, prod_q;
   logic [SQ_BITS-1:0]    sq_i_ff, sq_q_ff;
   logic [PWR_BITS-1:0]   pwr_ff;

   logic [ACC_BITS:0]     acc_sum;
   logic [ACC_BITS-1:0]   acc_sat;
   logic [FREQ_BITS:0]    freq_sum;
   logic                  in_sweep;
   logic [QCNT_BITS:0]    occupancy;

   // Hold off input while the queue could not take every window end in flight
   assign occupancy = (QCNT_BITS + 1)'(q_count)
                    + (QCNT_BITS + 1)'(s1_valid_ff & s1_end_ff)
                    + (QCNT_BITS + 1)'(s2_valid_ff & s2_end_ff);
   assign req_ready = occupancy < (QCNT_BITS + 1)'(QUEUE_DEPTH);
   assign accept    = req_valid & req_ready;

   // Window phase: count every beat, a zero length ends each window at once
   assign count_inc  = count_ff + WLEN_BITS'(1);
   assign window_end = count_inc >= cfg.window_length;

   always_comb begin
      settling_in = settling_ff;
      count_in    = count_ff;
      s1_valid_in = 1'b0;
      s1_end_in   = 1'b0;
      if (accept) begin
         count_in = count_inc;
         if (settling_ff) begin
            if (window_end) begin
               settling_in = 1'b0;
               count_in    = '0;
            end
         end else begin
            s1_valid_in = 1'b1;
            s1_end_in   = window_end;
            if (window_end) begin
               settling_in = 1'b1;
               count_in    = '0;
            end
         end
      end
   end

   // Square both components
   assign si     = req_sample_i;
   assign sq     = req_sample_q;
   assign prod_i = si * si;
   assign prod_q = sq * sq;

   // Saturating accumulate and sweep advance
   assign acc_sum  = {1'b0, acc_ff} + (ACC_BITS + 1)'(pwr_ff);
   assign acc_sat  = acc_sum[ACC_BITS] ? '1 : acc_sum[ACC_BITS-1:0];
   assign freq_sum = {1'b0, freq_ff} + {1'b0, cfg.frequency_step};
   assign in_sweep = freq_ff <= cfg.stop_frequency;

   assign s2_valid_in = s1_valid_ff;
   assign s2_end_in   = s1_end_ff;

   always_comb begin
      acc_in  = acc_ff;
      freq_in = freq_ff;
      q_push  = 1'b0;
      if (s2_valid_ff) begin
         acc_in = acc_sat;
         if (s2_end_ff) begin
            acc_in = '0;
            if (in_sweep) begin
               q_push  = 1'b1;
               freq_in = freq_sum[FREQ_BITS] ? '1 : freq_sum[FREQ_BITS-1:0];
            end
         end
      end
      if (freq_load.load) begin
         freq_in = freq_load.value;
      end
   end

   assign q_job.freq      = freq_ff;
   assign q_job.power_sum = acc_sat;

   // Control and accumulator state
   always_ff @(posedge clock) begin
      if (reset) begin
         settling_ff <= 1'b1;
         count_ff    <= '0;
         s1_valid_ff <= 1'b0;
         s1_end_ff   <= 1'b0;
         s2_valid_ff <= 1'b0;
         s2_end_ff   <= 1'b0;
         acc_ff      <= '0;
         freq_ff     <= '0;
      end else begin
         settling_ff <= settling_in;
         count_ff    <= count_in;
         s1_valid_ff <= s1_valid_in;
         s1_end_ff   <= s1_end_in;
         s2_valid_ff <= s2_valid_in;
         s2_end_ff   <= s2_end_in;
         acc_ff      <= acc_in;
         freq_ff     <= freq_in;
      end
   end

   // Datapath stages
   always_ff @(posedge clock) begin
      sq_i_ff <= prod_i[SQ_BITS-1:0];
      sq_q_ff <= prod_q[SQ_BITS-1:0];
      pwr_ff  <= PWR_BITS'(sq_i_ff) + PWR_BITS'(sq_q_ff);
   end

   a_settle_no_sample: assert property (@(posedge clock) disable iff (reset)
      (accept && settling_ff) |=> !s1_valid_ff)
      else $error("settle beat entered the power pipeline");

   a_push_has_room: assert property (@(posedge clock) disable iff (reset)
      q_push |-> (q_count < QCNT_BITS'(QUEUE_DEPTH)))
      else $error("window result pushed into a full queue");

endmodule

`default_nettype wire

// ----- rtl/swm_queue.sv -----
`default_nettype none

module swm_queue (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          push,
   input  wire swm_pkg::job_type              push_job,
   input  wire logic                          pop,
   output swm_pkg::job_type                   pop_job,
   output logic [swm_pkg::QCNT_BITS-1:0]      count
);
   import swm_pkg::*;

   job_type                mem_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [QCNT_BITS-1:0]   count_ff, count_in;

   assign pop_job = mem_ff[rd_ptr_ff];
   assign count   = count_ff;

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + QCNT_BITS'(1);
      end else if (pop && !push) begin
         count_in = count_ff - QCNT_BITS'(1);
      end
   end

   // Advance pointers
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + QPTR_BITS'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + QPTR_BITS'(1);
         end
      end
   end

   // Store entries
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_job;
      end
   end

   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> (count_ff != '0))
      else $error("pop from empty queue");

endmodule

`default_nettype wire

// ----- rtl/swm_back.sv -----
`default_nettype none

module swm_back (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire swm_pkg::cfg_type              cfg,
   input  wire logic [swm_pkg::QCNT_BITS-1:0] q_count,
   input  wire swm_pkg::job_type              q_job,
   output logic                               q_pop,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic [swm_pkg::FREQ_BITS-1:0]      rsp_sweep_frequency,
   output logic [swm_pkg::RMS_BITS-1:0]       rsp_rms_value
);
   import swm_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIV,
      ST_ROOT,
      ST_DONE
   } state_type;

   state_type              state_ff;
   logic [STEP_BITS-1:0]   step_ff;
   logic [ACC_BITS-1:0]    dq_ff;
   logic [WLEN_BITS-1:0]   rem_ff;
   logic [SREM_BITS-1:0]   srem_ff;
   logic [ROOT_BITS-1:0]   root_ff;
   logic [FREQ_BITS-1:0]   freq_ff;
   logic                   rsp_valid_ff;
   logic [FREQ_BITS-1:0]   rsp_freq_ff;
   logic [RMS_BITS-1:0]    rsp_rms_ff;

   logic [WLEN_BITS-1:0]   divisor;
   logic [WLEN_BITS:0]     div_shift;
   logic [WLEN_BITS:0]     div_diff;
   logic                   div_ge;
   logic [SREM_BITS+1:0]   root_cand;
   logic [SREM_BITS+1:0]   root_trial;
   logic [SREM_BITS+1:0]   root_diff;
   logic                   root_ge;
   logic [RMS_BITS-1:0]    rms_sat;
   logic                   out_free;

   // Restoring divide, one quotient bit per cycle
   assign divisor   = (cfg.window_length == '0) ? WLEN_BITS'(1) : cfg.window_length;
   assign div_shift = {rem_ff, dq_ff[ACC_BITS-1]};
   assign div_diff  = div_shift - {1'b0, divisor};
   assign div_ge    = div_shift >= {1'b0, divisor};

   // Digit-by-digit square root, two radicand bits per cycle
   assign root_cand  = {srem_ff, dq_ff[ACC_BITS-1:ACC_BITS-2]};
   assign root_trial = (SREM_BITS + 2)'({root_ff, 2'b01});
   assign root_diff  = root_cand - root_trial;
   assign root_ge    = root_cand >= root_trial;

   assign rms_sat  = (root_ff[ROOT_BITS-1:RMS_BITS] != '0) ? '1 : root_ff[RMS_BITS-1:0];
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign q_pop    = (state_ff == ST_IDLE) && (q_count != '0);

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_sweep_frequency = rsp_freq_ff;
   assign rsp_rms_value       = rsp_rms_ff;

   // Sequence one job through divide, root and the output register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if ((state_ff == ST_DONE) && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (q_pop) begin
                  dq_ff    <= q_job.power_sum;
                  freq_ff  <= q_job.freq;
                  rem_ff   <= '0;
                  step_ff  <= '0;
                  state_ff <= ST_DIV;
               end
            end
            ST_DIV: begin
               rem_ff  <= div_ge ? div_diff[WLEN_BITS-1:0] : div_shift[WLEN_BITS-1:0];
               dq_ff   <= {dq_ff[ACC_BITS-2:0], div_ge};
               if (step_ff == STEP_BITS'(ACC_BITS - 1)) begin
                  step_ff  <= '0;
                  srem_ff  <= '0;
                  root_ff  <= '0;
                  state_ff <= ST_ROOT;
               end else begin
                  step_ff <= step_ff + STEP_BITS'(1);
               end
            end
            ST_ROOT: begin
               srem_ff <= root_ge ? root_diff[SREM_BITS-1:0] : root_cand[SREM_BITS-1:0];
               root_ff <= {root_ff[ROOT_BITS-2:0], root_ge};
               dq_ff   <= {dq_ff[ACC_BITS-3:0], 2'b00};
               step_ff <= step_ff + STEP_BITS'(1);
               if (step_ff == STEP_BITS'(ROOT_BITS - 1)) begin
                  state_ff <= ST_DONE;
               end
            end
            ST_DONE: begin
               if (out_free) begin
                  rsp_freq_ff  <= freq_ff;
                  rsp_rms_ff   <= rms_sat;
                  state_ff     <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   a_div_steps: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |-> (step_ff < STEP_BITS'(ACC_BITS)))
      else $error("divide ran past its bit count");

   a_root_rem_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ROOT) |-> (srem_ff <= SREM_BITS'({root_ff, 1'b0})))
      else $error("square root remainder out of bound");

endmodule

`default_nettype wire

// ----- sim/tb_top.sv -----
// Expected readings from the sweep; holds its own copy of the meter state
class rms_sweep_scoreboard;
   typedef struct {
      logic [31:0] freq;
      logic [15:0] rms;
   } reading_type;

   logic [15:0] win_len;
   logic [31:0] start_freq;
   logic [31:0] stop_freq;
   logic [31:0] freq_step;
   logic [31:0] sweep_freq;
   logic [47:0] power_sum;
   logic [15:0] win_count;
   bit          settle_phase;
   reading_type pending_readings[$];
   int          errors;
   int          samples;
   int          checked;

   function new();
      win_len      = 16'd1024;
      start_freq   = 32'd0;
      stop_freq    = 32'd0;
      freq_step    = 32'd1;
      sweep_freq   = 32'd0;
      power_sum    = 48'd0;
      win_count    = 16'd0;
      settle_phase = 1'b1;
      errors       = 0;
      samples      = 0;
      checked      = 0;
   endfunction

   function void write_reg(swm_pkg::csr_index_type idx, logic [31:0] data);
      case (idx)
         swm_pkg::CSR_WINDOW_LENGTH: win_len = data[15:0];
         swm_pkg::CSR_START_FREQUENCY: begin
            // a new start point restarts the sweep, not the window
            start_freq = data;
            sweep_freq = data;
         end
         swm_pkg::CSR_STOP_FREQUENCY: stop_freq = data;
         swm_pkg::CSR_FREQUENCY_STEP: freq_step = data;
         default: ;
      endcase
   endfunction

   // Floor square root, one result bit per pass from the top
   function logic [23:0] floor_root(logic [47:0] n);
      logic [23:0] r;
      logic [47:0] sq;
      r = 24'd0;
      for (int b = 23; b >= 0; b--) begin
         r[b] = 1'b1;
         sq = {24'd0, r};
         sq = sq * sq;
         if (sq > n)
            r[b] = 1'b0;
      end
      return r;
   endfunction

   function void note_sample(logic signed [15:0] si, logic signed [15:0] sq);
      longint          wi;
      longint          wq;
      longint unsigned pw;
      longint unsigned room;
      logic [47:0]     divisor;
      logic [23:0]     root;
      logic [15:0]     rms;
      logic [32:0]     next_freq;
      bit              wend;
      samples++;
      win_count = win_count + 16'd1;
      wend = (win_count >= win_len);
      // settle window: count only
      if (settle_phase) begin
         if (wend) begin
            settle_phase = 1'b0;
            win_count    = 16'd0;
         end
         return;
      end
      // accumulate power, saturating at full scale
      wi = si;
      wq = sq;
      pw = wi * wi + wq * wq;
      room = 48'hFFFF_FFFF_FFFF - power_sum;
      if (pw > room)
         power_sum = '1;
      else
         power_sum = power_sum + pw[47:0];
      if (!wend)
         return;
      // end of measure window: mean, root, report if still in the sweep
      divisor = (win_len == 16'd0) ? 48'd1 : {32'd0, win_len};
      root = floor_root(power_sum / divisor);
      power_sum    = 48'd0;
      win_count    = 16'd0;
      settle_phase = 1'b1;
      rms = (root > 24'd65535) ? 16'hFFFF : root[15:0];
      if (sweep_freq <= stop_freq) begin
         pending_readings.push_back('{sweep_freq, rms});
         next_freq = {1'b0, sweep_freq} + {1'b0, freq_step};
         sweep_freq = next_freq[32] ? 32'hFFFF_FFFF : next_freq[31:0];
      end
   endfunction

   function void check_result(logic [31:0] freq, logic [15:0] rms);
      reading_type want;
      if (pending_readings.size() == 0) begin
         $display("%0t: unexpected reading, expected none, got freq=%0d rms=%0d",
                  $time, freq, rms);
         errors++;
         return;
      end
      want = pending_readings.pop_front();
      checked++;
      if (freq !== want.freq) begin
         $display("%0t: sweep_frequency mismatch, expected %0d, got %0d",
                  $time, want.freq, freq);
         errors++;
      end
      if (rms !== want.rms) begin
         $display("%0t: rms_value mismatch, expected %0d, got %0d",
                  $time, want.rms, rms);
         errors++;
      end
   endfunction

   function int pending();
      return pending_readings.size();
   endfunction
endclass

module tb_top;
   import swm_pkg::*;

   localparam int SETTLE_CYCLES = 400;
   localparam int STALL_LIMIT   = 10000;
   localparam int RANDOM_PHASES = 12;
   localparam int PHASE_ITEMS   = 100;
   localparam int HOLD_PHASE    = 8;
   localparam int HOLD_CYCLES   = 500;

   logic                 clock = 1'b0;
   logic                 reset;
   logic                 req_valid;
   logic                 req_ready;
   logic [15:0]          req_sample_i;
   logic [15:0]          req_sample_q;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic [FREQ_BITS-1:0] rsp_sweep_frequency;
   logic [RMS_BITS-1:0]  rsp_rms_value;
   logic                 csr_we;
   logic [CSR_AW-1:0]    csr_index;
   logic [CSR_DW-1:0]    csr_wdata;

   rms_sweep_scoreboard sb;
   int send_idle_pct = 32;
   int recv_idle_pct = 88;
   int hold_request  = 0;
   int hold_left     = 0;
   int idle_run      = 0;

   // corner samples for the measure windows of the directed part
   logic [15:0] corner_i [8] = '{16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF,
                                 16'h5555, 16'hAAAA, 16'h0000, 16'h8000};
   logic [15:0] corner_q [8] = '{16'h8000, 16'h0000, 16'hFFFF, 16'h0000,
                                 16'hAAAA, 16'h5555, 16'h0000, 16'h7FFF};

   swept_windowed_rms_meter #(.SAMPLE_BITS(16)) u_dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_sample_i        (req_sample_i),
      .req_sample_q        (req_sample_q),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_sweep_frequency (rsp_sweep_frequency),
      .rsp_rms_value       (rsp_rms_value),
      .csr_we              (csr_we),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Receiver: random back-pressure, or a long hold when one is requested
   always @(negedge clock) begin
      if (hold_request > 0) begin
         hold_left    = hold_request;
         hold_request = 0;
      end
      if (hold_left > 0) begin
         rsp_ready <= 1'b0;
         hold_left = hold_left - 1;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Observe register writes, accepted samples and readings at the edge
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_we)
            sb.write_reg(csr_index_type'(csr_index), csr_wdata);
         if (req_valid && req_ready)
            sb.note_sample(req_sample_i, req_sample_q);
         if (rsp_valid && rsp_ready)
            sb.check_result(rsp_sweep_frequency, rsp_rms_value);
      end
   end

   // Watchdog: give up after too long without any beat
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         idle_run = 0;
      else
         idle_run = idle_run + 1;
      if (idle_run >= STALL_LIMIT) begin
         $display("%0t: no beat for %0d cycles", $time, STALL_LIMIT);
         $display("FAIL");
         $finish;
      end
   end

   // Offer one sample, idling first at random; hold until accepted
   task automatic push_sample(input logic [15:0] si, input logic [15:0] sq);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid    <= 1'b1;
      req_sample_i <= si;
      req_sample_q <= sq;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic write_csr(input csr_index_type idx, input logic [31:0] data);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(negedge clock);
      csr_we    <= 1'b0;
   endtask

   // Stop sending, wait for every reading, then let the back end go quiet
   task automatic quiesce();
      @(negedge clock);
      req_valid <= 1'b0;
      while (sb.pending() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic configure(input logic [15:0] wl, input logic [31:0] f0,
                            input logic [31:0] f1, input logic [31:0] fstep);
      quiesce();
      write_csr(CSR_WINDOW_LENGTH, {16'd0, wl});
      write_csr(CSR_STOP_FREQUENCY, f1);
      write_csr(CSR_FREQUENCY_STEP, fstep);
      write_csr(CSR_START_FREQUENCY, f0);
   endtask

   // full random, small magnitude, or full-scale corners
   function automatic logic [15:0] pick_sample(int style);
      logic [15:0] v;
      case (style)
         0: v = 16'($urandom);
         1: begin
            v = 16'($urandom_range(0, 63));
            if ($urandom_range(1))
               v = -v;
         end
         default: begin
            case ($urandom_range(4))
               0: v = 16'h8000;
               1: v = 16'h7FFF;
               2: v = 16'hFFFF;
               3: v = 16'h0001;
               default: v = 16'h0000;
            endcase
         end
      endcase
      return v;
   endfunction

   task automatic run_samples(input int n, input int style_lo);
      logic [15:0] si;
      logic [15:0] sq;
      for (int k = 0; k < n; k++) begin
         si = pick_sample($urandom_range(style_lo, 2));
         // a quarter of the samples are real-valued
         sq = ($urandom_range(3) == 0) ? 16'h0000 : pick_sample($urandom_range(style_lo, 2));
         push_sample(si, sq);
      end
   endtask

   initial begin
      logic [15:0] wl;
      logic [31:0] f0;
      logic [31:0] f1;
      logic [31:0] fstep;
      sb = new();
      reset        = 1'b1;
      req_valid    = 1'b0;
      req_sample_i = 16'h0000;
      req_sample_q = 16'h0000;
      csr_we       = 1'b0;
      csr_index    = CSR_WINDOW_LENGTH;
      csr_wdata    = '0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Reset settings: a few settle samples, then shorten the window under them
      push_sample(16'h8000, 16'h8000);
      push_sample(16'h7FFF, 16'h7FFF);
      push_sample(16'h0000, 16'h0000);
      configure(16'd1, 32'd100, 32'd200, 32'd10);
      for (int k = 0; k < 8; k++) begin
         push_sample(16'h1234, 16'hFEDC);
         push_sample(corner_i[k], corner_q[k]);
      end
      // zero window length, sweep running into frequency saturation
      configure(16'd0, 32'hFFFF_FFF0, 32'hFFFF_FFFF, 32'd8);
      repeat (4) push_sample(pick_sample(0), pick_sample(0));

      // Random phases: idle profile per third, fresh settings per phase
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         case ($urandom_range(9))
            0, 1, 2, 3, 4, 5: wl = 16'($urandom_range(0, 6));
            6, 7, 8:          wl = 16'($urandom_range(7, 40));
            default:          wl = 16'($urandom_range(41, 120));
         endcase
         case ($urandom_range(4))
            0: begin
               f0    = $urandom;
               fstep = $urandom_range(1, 1000);
               f1    = f0 + fstep * $urandom_range(0, 40);
            end
            1: begin
               // stop below start: windows run but nothing is reported
               f0    = $urandom | 32'h1;
               f1    = f0 - 32'd1;
               fstep = $urandom;
            end
            2: begin
               f0    = 32'hFFFF_FFFF - $urandom_range(0, 5000);
               f1    = 32'hFFFF_FFFF;
               fstep = $urandom_range(100, 3000);
            end
            3: begin
               f0    = $urandom;
               f1    = f0;
               fstep = 32'd0;
            end
            default: begin
               f0    = 32'd0;
               f1    = 32'hFFFF_FFFF;
               fstep = 32'hFFFF_FFFF;
            end
         endcase
         if (p == HOLD_PHASE) begin
            wl    = 16'd1;
            f0    = 32'd0;
            f1    = 32'hFFFF_FFFF;
            fstep = 32'd1;
         end
         configure(wl, f0, f1, fstep);
         if (p < RANDOM_PHASES / 3) begin
            send_idle_pct = 32;
            recv_idle_pct = 88;
         end else if (p < 2 * RANDOM_PHASES / 3) begin
            send_idle_pct = 88;
            recv_idle_pct = 32;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         // hold off the receiver so the job queue fills and input stalls
         if (p == HOLD_PHASE)
            hold_request = HOLD_CYCLES;
         run_samples(PHASE_ITEMS, 0);
      end

      // Long window, small and full-scale samples: one reading at a fixed frequency
      configure(16'd300, 32'd7, 32'd7, 32'd0);
      run_samples(2 * 300, 1);

      quiesce();
      $display("Covered %0d samples and %0d readings over %0d register settings,",
               sb.samples, sb.checked, RANDOM_PHASES + 4);
      $display("window lengths 0 to 300, saturating sweeps, stalls and idles on both sides.");
      if (sb.errors == 0 && sb.pending() == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end
endmodule
